FILE: rtl/fbpa_pkg.sv
package fbpa_pkg;

  localparam int POOL_DEPTH = 256;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 17;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 9;
  localparam int OUT_W    = 48;
  localparam int CFG_IDX_W = 2;

  localparam int WORD_W = 16;
  localparam int WB_W   = $clog2(WORD_W);
  localparam int WORDS  = (POOL_DEPTH + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int GIDX_W = WIDX_W + WB_W;
  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int DIV_W  = IDX_W + SIZE_W;
  localparam int SPAN_W = CNT_W + SIZE_W;
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam int CMP_W  = GIDX_W + CNT_W;
  localparam int DCNT_W = $clog2(IDX_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_BLOCK_SIZE   = 2'd1,
    CFG_BLOCK_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_NO_FREE      = 3'd1,
    STATUS_OUT_OF_RANGE = 3'd2,
    STATUS_MISALIGNED   = 3'd3,
    STATUS_NOT_IN_USE   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ALLOC,
    OP_RELEASE
  } scan_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_CHECK,
    S_DIV,
    S_SCAN,
    S_ADDR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] quot;
    logic             exact;
  } div_res_t;

  function automatic logic [WB_W:0] popcnt(input logic [WORD_W-1:0] w);
    logic [WB_W:0] s;
    s = '0;
    for (int i = 0; i < WORD_W; i++) begin
      s = s + (WB_W+1)'(w[i]);
    end
    return s;
  endfunction

  function automatic logic [WB_W-1:0] lowest(input logic [WORD_W-1:0] w);
    logic [WB_W-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        p = WB_W'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/fbpa_cell.sv
module fbpa_cell import fbpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [WORD_W-1:0] word_i,
  output logic [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] word_q, word_d;

  assign word_d = shift_i ? word_i : word_q;
  assign word_o = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

endmodule

FILE: rtl/fbpa_div.sv
module fbpa_div import fbpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output div_res_t          res_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [IDX_W-1:0]  quot_q, quot_d;
  logic              ge;

  localparam logic [DCNT_W-1:0] LastStep = DCNT_W'(IDX_W - 1);

  assign ge = (rem_q >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      dvs_d  = DIV_W'(divisor_i) << (IDX_W - 1);
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_q - dvs_q : rem_q;
      quot_d = (quot_q << 1) | IDX_W'(ge);
      dvs_d  = dvs_q >> 1;
      cnt_d  = cnt_q + DCNT_W'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o      = done_q;
  assign res_o.quot  = quot_q;
  assign res_o.exact = (rem_q == '0);

endmodule

FILE: rtl/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator. One used bit per block lives in a ring of word cells,
// all cleared by reset, so the block is ready right after reset. Every transaction sweeps
// the ring once (one word of 16 blocks per cycle) to find and mark the lowest free block
// on an allocate or to clear the released block's bit on a release, and to count free blocks.
// A release in range first turns its address into a block index with a restoring divider
// that resolves one index bit per cycle (8 steps).
// A result waits in an output register while the next transaction is accepted.
module fixed_block_pool_allocator_core import fbpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [ADDR_W-1:0]    s_axis_tdata_i,   // release_address
  input  logic                 s_axis_tuser_i,   // mode
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OUT_W-1:0]     m_axis_tdata_o,   // block_address, status, free_count, pad
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam logic [WIDX_W-1:0] LastWord = WIDX_W'(WORDS - 1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  base_q;
  logic [SIZE_W-1:0]  bsize_q;
  logic [COUNT_W-1:0] bcount_q;

  scan_op_e          op_q;
  logic [ADDR_W-1:0] offset_q;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  n_q;
  logic [SPAN_W-1:0] span_q;
  status_e           status_q;
  logic [IDX_W-1:0]  idx_q;
  logic              found_q;
  logic [WIDX_W-1:0] scan_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] prod_q;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic              in_fire;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  div_res_t          div_res;

  logic [SIZE_W-1:0] size_eff;
  logic [CNT_W-1:0]  n_eff;

  logic [WORD_W-1:0] cell_word [WORDS];
  logic [WORD_W-1:0] head, head_mod, active, free_pre;
  logic [WB_W-1:0]   pos;
  logic              alloc_hit, rel_match;
  logic [GIDX_W-1:0] gidx_rel;
  logic              scanning;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign out_load        = (state_q == S_RESP) && (!out_valid_q || m_axis_tready_i);
  assign div_start       = (state_q == S_CHECK) && (ADDR_W'(span_q) > offset_q);
  assign scanning        = (state_q == S_SCAN);

  assign size_eff = (bsize_q == '0) ? SIZE_W'(1) : bsize_q;
  assign n_eff    = (32'(bcount_q) > 32'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : CNT_W'(bcount_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      bsize_q  <= SIZE_W'(4096);
      bcount_q <= COUNT_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS: base_q   <= cfg_data_i;
        CFG_BLOCK_SIZE:   bsize_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_BLOCK_COUNT:  bcount_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < WORDS; g++) begin : g_ring
    logic [WORD_W-1:0] next_word;
    if (g == WORDS - 1) begin : g_tail
      assign next_word = head_mod;
    end else begin : g_link
      assign next_word = cell_word[g+1];
    end
    fbpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (scanning),
      .word_i  (next_word),
      .word_o  (cell_word[g])
    );
  end

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(offset_q)),
    .divisor_i  (size_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  always_comb begin
    head     = cell_word[0];
    gidx_rel = GIDX_W'(idx_q);
    for (int j = 0; j < WORD_W; j++) begin
      active[j] = CMP_W'({scan_q, WB_W'(j)}) < CMP_W'(n_q);
    end
    free_pre  = ~head & active;
    pos       = lowest(free_pre);
    alloc_hit = (op_q == OP_ALLOC) && !found_q && (free_pre != '0);
    rel_match = (op_q == OP_RELEASE) && (gidx_rel[GIDX_W-1:WB_W] == scan_q);
    head_mod  = head;
    if (alloc_hit) begin
      head_mod = head | (WORD_W'(1) << pos);
    end else if (rel_match && head[gidx_rel[WB_W-1:0]]) begin
      head_mod = head & ~(WORD_W'(1) << gidx_rel[WB_W-1:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = (mode_e'(s_axis_tuser_i) == MODE_ALLOC) ? S_SCAN : S_SPAN;
      S_SPAN:  state_d = S_CHECK;
      S_CHECK: state_d = div_start ? S_DIV : S_SCAN;
      S_DIV:   if (div_done) state_d = S_SCAN;
      S_SCAN:  if (scan_q == LastWord) state_d = S_ADDR;
      S_ADDR:  state_d = S_RESP;
      S_RESP:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        offset_q <= s_axis_tdata_i - base_q;
        size_q   <= size_eff;
        n_q      <= n_eff;
        op_q     <= OP_ALLOC;
        status_q <= STATUS_NO_FREE;
        found_q  <= 1'b0;
        scan_q   <= '0;
        cnt_q    <= '0;
      end
      S_SPAN: begin
        span_q <= SPAN_W'(n_q * size_q);
        op_q   <= OP_NONE;
      end
      S_CHECK: begin
        if (!div_start) begin
          status_q <= STATUS_OUT_OF_RANGE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_q <= div_res.quot;
          if (div_res.exact) begin
            op_q     <= OP_RELEASE;
            status_q <= STATUS_NOT_IN_USE;
          end else begin
            status_q <= STATUS_MISALIGNED;
          end
        end
      end
      S_SCAN: begin
        scan_q <= scan_q + WIDX_W'(1);
        cnt_q  <= cnt_q + CNT_W'(popcnt(~head_mod & active));
        if (alloc_hit) begin
          found_q  <= 1'b1;
          idx_q    <= IDX_W'({scan_q, pos});
          status_q <= STATUS_OK;
        end else if (rel_match && head[gidx_rel[WB_W-1:0]]) begin
          status_q <= STATUS_OK;
        end
      end
      S_ADDR: begin
        prod_q <= PROD_W'(idx_q * size_q);
      end
      S_RESP: begin
        if (out_load) begin
          out_data_q <= OUT_W'({FREE_W'(cnt_q), status_q,
                                ((op_q == OP_ALLOC && found_q) ?
                                 base_q + ADDR_W'(prod_q) : ADDR_W'(0))});
        end
      end
      default: ;
    endcase
  end

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside of the divide phase");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted transaction did not start work");

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      32'(m_axis_tdata_o[ADDR_W+STATUS_W+FREE_W-1:ADDR_W+STATUS_W]) <= 32'(POOL_DEPTH))
    else $error("free count exceeds the pool depth");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[ADDR_W+STATUS_W-1:ADDR_W] <= STATUS_NOT_IN_USE)
    else $error("undefined status code in result");

endmodule
